// ===== rtl/core/krs_pkg.sv =====
// Shared types and constants for the key record search scanner.
`default_nettype none

package krs_pkg;

  localparam logic [15:0] MasterKeyPlace = 16'h8000;
  localparam logic [15:0] RecordBytes    = 16'd8;
  localparam logic [7:0]  MarkUsed       = 8'h01;
  localparam logic [7:0]  MarkEnd        = 8'hFF;
  localparam logic [15:0] NoFree         = 16'h0001;
  localparam logic [2:0]  MismatchInit   = 3'd6;
  localparam logic [2:0]  LastBytePos    = 3'd7;

  localparam logic        ModeBegin      = 1'b0;

  localparam logic [1:0]  CfgKeyValue    = 2'd0;
  localparam logic [1:0]  CfgStartAddr   = 2'd1;
  localparam logic [1:0]  CfgSearchLimit = 2'd2;

  typedef enum logic [2:0] {
    StEmpty       = 3'd0,
    StFound       = 3'd1,
    StLimitHigh   = 3'd2,
    StStartBeyond = 3'd3,
    StExhausted   = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] rec_addr;
    logic [2:0]  byte_pos;
    logic [2:0]  mis_cnt;
    logic [15:0] free_addr;
    logic        searching;
  } scan_state_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] found_addr;
    logic [15:0] free_addr;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/krs_step.sv =====
// Next-state and result logic for one request of the record scanner.
`default_nettype none

module krs_step import krs_pkg::*; (
  input  wire logic        mode_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [63:0] key_value_i,
  input  wire logic [15:0] start_addr_i,
  input  wire logic [15:0] search_limit_i,
  input  wire scan_state_t state_i,
  output scan_state_t      state_o,
  output logic             res_valid_o,
  output scan_res_t        res_o
);

  logic [7:0]  key_byte;
  logic [15:0] next_rec;

  // key byte at the current position within the record
  assign key_byte = key_value_i[{state_i.byte_pos, 3'b000} +: 8];
  assign next_rec = state_i.rec_addr + RecordBytes;

  always_comb begin
    state_o        = state_i;
    res_valid_o    = 1'b0;
    res_o.status   = StEmpty;
    res_o.found_addr = state_i.rec_addr;
    res_o.free_addr  = state_i.free_addr;

    if (mode_i == ModeBegin) begin
      state_o.searching = 1'b0;
      if (search_limit_i >= MasterKeyPlace) begin
        res_valid_o      = 1'b1;
        res_o.status     = StLimitHigh;
        res_o.found_addr = start_addr_i;
      end else if (start_addr_i > search_limit_i) begin
        res_valid_o      = 1'b1;
        res_o.status     = StStartBeyond;
        res_o.found_addr = start_addr_i;
      end else begin
        state_o.free_addr = NoFree;
        state_o.rec_addr  = start_addr_i;
        state_o.byte_pos  = '0;
        state_o.mis_cnt   = MismatchInit;
        res_o.free_addr   = NoFree;
        res_o.found_addr  = start_addr_i;
        if (start_addr_i >= search_limit_i) begin
          res_valid_o  = 1'b1;
          res_o.status = StExhausted;
        end else begin
          state_o.searching = 1'b1;
        end
      end
    end else if (state_i.searching) begin
      if (state_i.byte_pos == '0) begin
        // marker byte
        state_o.mis_cnt  = MismatchInit;
        state_o.byte_pos = 3'd1;
        if (data_byte_i != MarkUsed) begin
          if (state_i.free_addr == NoFree) begin
            state_o.free_addr = state_i.rec_addr;
            res_o.free_addr   = state_i.rec_addr;
          end
          if (data_byte_i == MarkEnd) begin
            state_o.searching = 1'b0;
            res_valid_o       = 1'b1;
            res_o.status      = StEmpty;
          end
        end
      end else if (state_i.byte_pos != LastBytePos) begin
        if (data_byte_i == key_byte && state_i.mis_cnt != '0) begin
          state_o.mis_cnt = state_i.mis_cnt - 3'd1;
        end
        state_o.byte_pos = state_i.byte_pos + 3'd1;
      end else if (data_byte_i == key_byte && state_i.mis_cnt == '0) begin
        state_o.searching = 1'b0;
        res_valid_o       = 1'b1;
        res_o.status      = StFound;
      end else begin
        state_o.rec_addr = next_rec;
        state_o.byte_pos = '0;
        state_o.mis_cnt  = MismatchInit;
        res_o.found_addr = next_rec;
        if (next_rec >= search_limit_i) begin
          state_o.searching = 1'b0;
          res_valid_o       = 1'b1;
          res_o.status      = StExhausted;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/key_record_search_scanner_top.sv =====
// Results are registered in the output register, or in the skid entry while it is held.
// Throughput: one request per cycle while in_stall_o is low; state updates on acceptance.
// A two-entry output stage (result register plus skid) keeps input and output apart;
// the input stalls only while the skid entry is occupied.
// Reset (rst_ni low, asynchronous) clears config and flags, idles scan, first-free to 1.
`default_nettype none

module key_record_search_scanner_top import krs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      found_address_o,
  output logic [15:0]      first_free_address_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  logic [63:0] key_q;
  logic [15:0] start_q;
  logic [15:0] limit_q;

  scan_state_t state_q, state_d;
  logic        res_valid;
  scan_res_t   res;

  logic        out_valid_q, skid_valid_q;
  scan_res_t   out_q, skid_q;
  logic        in_acc, out_pop, produce;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_pop    = out_valid_q && !out_stall_i;
  assign produce    = in_acc && res_valid;

  krs_step u_step (
    .mode_i         (mode_i),
    .data_byte_i    (data_byte_i),
    .key_value_i    (key_q),
    .start_addr_i   (start_q),
    .search_limit_i (limit_q),
    .state_i        (state_q),
    .state_o        (state_d),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      start_q <= '0;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgKeyValue:    key_q   <= cfg_data_i;
        CfgStartAddr:   start_q <= cfg_data_i[15:0];
        CfgSearchLimit: limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.rec_addr  <= '0;
      state_q.byte_pos  <= '0;
      state_q.mis_cnt   <= MismatchInit;
      state_q.free_addr <= NoFree;
      state_q.searching <= 1'b0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_pop) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (produce) begin
        if (!out_valid_q || out_pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (produce) begin
      if (!out_valid_q || out_pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_q.status;
  assign found_address_o      = out_q.found_addr;
  assign first_free_address_o = out_q.free_addr;

endmodule

`default_nettype wire
